[rtl/positional_ordered_list_defines.svh]
// Assertion macros for the positional ordered list; clk and arst_n are taken from the using scope.
`ifndef POSITIONAL_ORDERED_LIST_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_DEFINES_SVH
`ifndef SYNTHESIS
`define POL_ASSERT_NOW(lbl, cond, conseq, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);
`define POL_ASSERT_NEXT(lbl, cond, conseq, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);
`else
`define POL_ASSERT_NOW(lbl, cond, conseq, msg)
`define POL_ASSERT_NEXT(lbl, cond, conseq, msg)
`endif
`endif

[rtl/pol_pkg.sv]
// Types and constants shared by the positional ordered list modules.
`default_nettype none
package pol_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int POS_W          = 7;
	localparam int CNT_OUT_W      = 7;
	localparam int WORD_W         = 32;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2
	} pol_op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} pol_status_t;

	typedef struct packed {
		logic [1:0]               op;
		logic signed [WORD_W-1:0] value;
		logic [POS_W-1:0]         position;
	} pol_req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic [CNT_OUT_W-1:0]     count;
		logic signed [WORD_W-1:0] read_value;
	} pol_rsp_t;

	// shift controls broadcast to every cell; idx is the 0-based position
	typedef struct packed {
		logic             ins;
		logic             del;
		logic [POS_W-1:0] idx;
	} pol_ctrl_t;

endpackage
`default_nettype wire

[rtl/pol_cell.sv]
// One list slot: holds a word and shifts toward or away from its neighbors.
`default_nettype none
module pol_cell #(
	parameter int DATA_WIDTH = pol_pkg::DATA_WIDTH_DEF,
	parameter int INDEX      = 0,
	parameter int CMP_W      = 8
) (
	input  wire logic                  clk,
	input  wire pol_pkg::pol_ctrl_t    ctrl,
	input  wire logic [DATA_WIDTH-1:0] new_word,
	input  wire logic [DATA_WIDTH-1:0] left,
	input  wire logic [DATA_WIDTH-1:0] right,
	output logic      [DATA_WIDTH-1:0] word,
	output logic      [DATA_WIDTH-1:0] rd_word
);
	import pol_pkg::*;

	localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

	logic [DATA_WIDTH-1:0] data_q;
	logic [CMP_W-1:0]      idx_e;
	logic                  hit;

	assign idx_e   = CMP_W'(ctrl.idx);
	assign hit     = (idx_e == MY_IDX);
	assign word    = data_q;
	assign rd_word = hit ? data_q : '0;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (MY_IDX > idx_e) begin
				data_q <= left;
			end else if (hit) begin
				data_q <= new_word;
			end
		end else if (ctrl.del && MY_IDX >= idx_e) begin
			data_q <= right;
		end
	end

endmodule
`default_nettype wire

[rtl/positional_ordered_list.sv]
// Top level of the positional ordered list: control, cell chain and result register.
//  channel | valid     | stall     | payload
//  request | req_valid | req_stall | req (op, value, position)
//  result  | rsp_valid | rsp_stall | rsp (status, count, read_value)
// One item per cycle while req_stall is low: the whole cell row shifts in the cycle the item is taken.
// The result shows up in the result register in the cycle after the item is taken.
// req_stall follows a held result that is itself stalled.
// Reset clears only the element count and result valid; slot contents stay unknown.
`default_nettype none
`include "positional_ordered_list_defines.svh"
module positional_ordered_list #(
	parameter int CAPACITY   = pol_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = pol_pkg::DATA_WIDTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire pol_pkg::pol_req_t req,
	output logic            rsp_valid,
	input  wire logic       rsp_stall,
	output pol_pkg::pol_rsp_t rsp
);
	import pol_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_d;
	logic                  rsp_valid_q;
	pol_rsp_t              rsp_q;
	pol_rsp_t              rsp_d;
	logic                  acc_in;
	logic [CMP_W-1:0]      pos_e;
	logic [CMP_W-1:0]      cnt_e;
	logic                  pos_nz;
	logic                  full;
	logic                  ins_go;
	logic                  del_go;
	logic                  rd_go;
	pol_status_t           status_d;
	pol_ctrl_t             ctrl;
	logic [DATA_WIDTH-1:0] new_word;
	logic [DATA_WIDTH-1:0] sel_word;
	logic [WORD_W-1:0]     sel_w32;
	logic [DATA_WIDTH-1:0] words   [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_words[CAPACITY];

	assign req_stall = rsp_valid_q && rsp_stall;
	assign acc_in    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign pos_e  = CMP_W'(req.position);
	assign cnt_e  = CMP_W'(count_q);
	assign pos_nz = (req.position != '0);
	assign full   = (cnt_e == CMP_W'(CAPACITY));

	always_comb begin
		ins_go   = 1'b0;
		del_go   = 1'b0;
		rd_go    = 1'b0;
		status_d = ST_RANGE;
		unique case (req.op)
			OP_INSERT: begin
				if (pos_nz && pos_e <= cnt_e + 1'b1) begin
					if (full) begin
						status_d = ST_FULL;
					end else begin
						ins_go   = 1'b1;
						status_d = ST_DONE;
					end
				end
			end
			OP_DELETE: begin
				if (pos_nz && pos_e <= cnt_e) begin
					del_go   = 1'b1;
					rd_go    = 1'b1;
					status_d = ST_DONE;
				end
			end
			OP_READ: begin
				if (pos_nz && pos_e <= cnt_e) begin
					rd_go    = 1'b1;
					status_d = ST_DONE;
				end
			end
			default: status_d = ST_RANGE;
		endcase
	end

	assign ctrl.ins = acc_in && ins_go;
	assign ctrl.del = acc_in && del_go;
	assign ctrl.idx = req.position - 1'b1;

	generate
		if (DATA_WIDTH > WORD_W) begin : g_fit_wide
			assign new_word = {{(DATA_WIDTH-WORD_W){req.value[WORD_W-1]}}, req.value};
		end else begin : g_fit_narrow
			assign new_word = req.value[DATA_WIDTH-1:0];
		end
		if (DATA_WIDTH >= WORD_W) begin : g_rd_wide
			assign sel_w32 = sel_word[WORD_W-1:0];
		end else begin : g_rd_narrow
			assign sel_w32 = {{(WORD_W-DATA_WIDTH){sel_word[DATA_WIDTH-1]}}, sel_word};
		end
	endgenerate

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic [DATA_WIDTH-1:0] left_w;
			logic [DATA_WIDTH-1:0] right_w;
			if (gi == 0) begin : g_first
				assign left_w = '0;
			end else begin : g_mid_l
				assign left_w = words[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign right_w = '0;
			end else begin : g_mid_r
				assign right_w = words[gi+1];
			end
			pol_cell #(
				.DATA_WIDTH(DATA_WIDTH),
				.INDEX     (gi),
				.CMP_W     (CMP_W)
			) u_cell (
				.clk     (clk),
				.ctrl    (ctrl),
				.new_word(new_word),
				.left    (left_w),
				.right   (right_w),
				.word    (words[gi]),
				.rd_word (rd_words[gi])
			);
		end
	endgenerate

	// at most one cell matches the position, so an OR picks its word
	always_comb begin
		sel_word = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			sel_word = sel_word | rd_words[i];
		end
	end

	always_comb begin
		count_d = count_q;
		if (ins_go) begin
			count_d = count_q + 1'b1;
		end else if (del_go) begin
			count_d = count_q - 1'b1;
		end
		rsp_d.status     = status_d;
		rsp_d.count      = CNT_OUT_W'(count_d);
		rsp_d.read_value = rd_go ? sel_w32 : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc_in) begin
				count_q <= count_d;
			end
			rsp_valid_q <= acc_in || req_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			rsp_q <= rsp_d;
		end
	end

	`POL_ASSERT_NOW(a_cnt_cap, 1'b1, count_q <= CNT_W'(CAPACITY), "count above capacity")
	`POL_ASSERT_NEXT(a_ins_cnt, acc_in && ins_go, count_q == $past(count_q) + 1'b1, "insert did not bump count")
	`POL_ASSERT_NEXT(a_rej_zero, acc_in && status_d != ST_DONE, rsp_q.read_value == '0 && count_q == $past(count_q), "rejected item changed state or value")

endmodule
`default_nettype wire

[bench/tb_positional_ordered_list.sv]
// Self-checking bench for the positional ordered list: directed table, random traffic, stalls.
`default_nettype none
module tb_positional_ordered_list;
	timeunit 1ns;
	timeprecision 1ps;

	import pol_pkg::*;

	localparam int LIST_DEPTH = CAPACITY_DEF;
	localparam int PHASE_ITEMS = 325;
	localparam int HOLD_CYCLES = 100;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic        fill;     // fill the list to capacity before this item
		logic        pinned;   // expected result typed in below
		logic [1:0]  op;
		logic [31:0] value;
		logic [6:0]  position;
		logic [1:0]  status;
		logic [6:0]  count;
		logic [31:0] rd;
	} step_t;

	localparam int NUM_STEPS = 26;
	localparam step_t STEPS [NUM_STEPS] = '{
		'{1'b0, 1'b1, OP_READ,   32'h0,        7'd1,   ST_RANGE, 7'd0,  32'h0},
		'{1'b0, 1'b1, OP_DELETE, 32'h0,        7'd1,   ST_RANGE, 7'd0,  32'h0},
		'{1'b0, 1'b1, OP_INSERT, 32'h1,        7'd0,   ST_RANGE, 7'd0,  32'h0},
		'{1'b0, 1'b1, OP_INSERT, 32'h1,        7'd2,   ST_RANGE, 7'd0,  32'h0},
		'{1'b0, 1'b1, OP_INSERT, 32'h7FFFFFFF, 7'd1,   ST_DONE,  7'd1,  32'h0},
		'{1'b0, 1'b1, OP_INSERT, 32'h80000000, 7'd1,   ST_DONE,  7'd2,  32'h0},
		'{1'b0, 1'b1, OP_INSERT, 32'hFFFFFFFF, 7'd3,   ST_DONE,  7'd3,  32'h0},
		'{1'b0, 1'b1, OP_INSERT, 32'h0,        7'd2,   ST_DONE,  7'd4,  32'h0},
		'{1'b0, 1'b1, OP_READ,   32'h0,        7'd1,   ST_DONE,  7'd4,  32'h80000000},
		'{1'b0, 1'b1, OP_READ,   32'h0,        7'd4,   ST_DONE,  7'd4,  32'hFFFFFFFF},
		'{1'b0, 1'b1, OP_READ,   32'h0,        7'd3,   ST_DONE,  7'd4,  32'h7FFFFFFF},
		'{1'b0, 1'b1, OP_READ,   32'h0,        7'd5,   ST_RANGE, 7'd4,  32'h0},
		'{1'b0, 1'b1, OP_DELETE, 32'h0,        7'd5,   ST_RANGE, 7'd4,  32'h0},
		'{1'b0, 1'b1, OP_UNUSED, 32'hAAAAAAAA, 7'd1,   ST_RANGE, 7'd4,  32'h0},
		'{1'b0, 1'b1, OP_INSERT, 32'h55555555, 7'd127, ST_RANGE, 7'd4,  32'h0},
		'{1'b0, 1'b1, OP_READ,   32'h0,        7'd127, ST_RANGE, 7'd4,  32'h0},
		'{1'b0, 1'b1, OP_DELETE, 32'h0,        7'd4,   ST_DONE,  7'd3,  32'hFFFFFFFF},
		'{1'b0, 1'b1, OP_DELETE, 32'h0,        7'd1,   ST_DONE,  7'd2,  32'h80000000},
		'{1'b0, 1'b1, OP_DELETE, 32'h0,        7'd2,   ST_DONE,  7'd1,  32'h7FFFFFFF},
		'{1'b0, 1'b1, OP_READ,   32'h12345678, 7'd1,   ST_DONE,  7'd1,  32'h0},
		'{1'b1, 1'b1, OP_INSERT, 32'h1,        7'd65,  ST_FULL,  7'd64, 32'h0},
		'{1'b0, 1'b1, OP_INSERT, 32'h1,        7'd66,  ST_RANGE, 7'd64, 32'h0},
		'{1'b0, 1'b1, OP_INSERT, 32'h1,        7'd1,   ST_FULL,  7'd64, 32'h0},
		'{1'b0, 1'b0, OP_DELETE, 32'h0,        7'd64,  ST_DONE,  7'd0,  32'h0},
		'{1'b0, 1'b1, OP_INSERT, 32'hDEADBEEF, 7'd64,  ST_DONE,  7'd64, 32'h0},
		'{1'b0, 1'b1, OP_READ,   32'h0,        7'd64,  ST_DONE,  7'd64, 32'hDEADBEEF}
	};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	pol_req_t  req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	pol_rsp_t  rsp;

	// list contents and length as the block should hold them
	logic signed [WORD_W-1:0] list_words [LIST_DEPTH];
	int        list_len = 0;
	pol_rsp_t  pending_rsp_q [$];
	pol_rsp_t  want_rsp;
	int        err_cnt = 0;
	int        send_idle_pct = 0;
	int        rsp_stall_pct = 0;
	logic      hold_tgl = 1'b0;
	logic      hold_seen = 1'b0;
	int        hold_left = 0;

	positional_ordered_list dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	task automatic note_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (err_cnt < 100)
			$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		err_cnt++;
	endtask

	// applies one item to the expected list and returns its result
	function automatic pol_rsp_t apply_list_op(input pol_req_t item);
		pol_rsp_t o;
		int p;
		int i;
		o = '0;
		o.status = ST_RANGE;
		p = int'(item.position);
		case (item.op)
		OP_INSERT: begin
			if (p >= 1 && p <= list_len + 1) begin
				if (list_len >= LIST_DEPTH) begin
					o.status = ST_FULL;
				end else begin
					for (i = list_len; i > p - 1; i--)
						list_words[i] = list_words[i - 1];
					list_words[p - 1] = item.value;
					list_len++;
					o.status = ST_DONE;
				end
			end
		end
		OP_DELETE, OP_READ: begin
			if (p >= 1 && p <= list_len) begin
				o.read_value = list_words[p - 1];
				if (item.op == OP_DELETE) begin
					for (i = p - 1; i + 1 < list_len; i++)
						list_words[i] = list_words[i + 1];
					list_len--;
				end
				o.status = ST_DONE;
			end
		end
		default: ;
		endcase
		o.count = CNT_OUT_W'(list_len);
		return o;
	endfunction

	task automatic offer_item(input pol_req_t item, input logic pinned, input pol_rsp_t pinned_rsp);
		pol_rsp_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall !== 1'b0);
		predicted = apply_list_op(item);
		pending_rsp_q.push_back(pinned ? pinned_rsp : predicted);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending_rsp_q.size() != 0);
	endtask

	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 19))
		0: return 32'h7FFFFFFF;
		1: return 32'h80000000;
		2: return 32'h0;
		3: return 32'hFFFFFFFF;
		default: return $urandom;
		endcase
	endfunction

	// grow_pct sets the share of inserts, so the length sweeps up or down
	function automatic pol_req_t random_list_item(input int grow_pct);
		pol_req_t item;
		int top;
		int roll;
		item.value = random_word();
		if ($urandom_range(0, 99) < 3) begin
			item.op = 2'($urandom_range(0, 3));
			item.position = 7'($urandom_range(0, 127));
			return item;
		end
		if ($urandom_range(0, 99) < grow_pct) begin
			item.op = OP_INSERT;
			top = list_len + 1;
		end else begin
			item.op = ($urandom_range(0, 99) < 70) ? OP_DELETE : OP_READ;
			top = (list_len == 0) ? 1 : list_len;
		end
		roll = $urandom_range(0, 99);
		if (roll < 4)
			item.position = 7'(top + 1);
		else if (roll < 28)
			item.position = 7'd1;
		else if (roll < 52)
			item.position = 7'(top);
		else
			item.position = 7'($urandom_range(1, top));
		return item;
	endfunction

	always @(posedge clk) begin
		if (hold_tgl != hold_seen) begin
			hold_seen <= hold_tgl;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
		rsp_stall <= (hold_tgl != hold_seen) || (hold_left > 1) ||
			($urandom_range(0, 99) < rsp_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (pending_rsp_q.size() == 0) begin
				note_mismatch("unexpected result", rsp.read_value, 32'h0);
			end else begin
				want_rsp = pending_rsp_q.pop_front();
				if (rsp.status !== want_rsp.status)
					note_mismatch("status", 32'(rsp.status), 32'(want_rsp.status));
				if (rsp.count !== want_rsp.count)
					note_mismatch("count", 32'(rsp.count), 32'(want_rsp.count));
				if (rsp.read_value !== want_rsp.read_value)
					note_mismatch("read_value", rsp.read_value, want_rsp.read_value);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		pol_req_t item;
		pol_rsp_t typed;
		int s;
		int ph;
		int n;
		int k;
		int send_pct [4];
		int stall_pct [4];
		send_pct = '{0, 55, 0, 19};
		stall_pct = '{0, 0, 55, 19};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (s = 0; s < NUM_STEPS; s++) begin
			if (STEPS[s].fill) begin
				while (list_len < LIST_DEPTH) begin
					item.op = OP_INSERT;
					item.value = random_word();
					item.position = 7'($urandom_range(1, list_len + 1));
					offer_item(item, 1'b0, '0);
				end
			end
			item.op = STEPS[s].op;
			item.value = STEPS[s].value;
			item.position = STEPS[s].position;
			typed.status = STEPS[s].status;
			typed.count = STEPS[s].count;
			typed.read_value = STEPS[s].rd;
			offer_item(item, STEPS[s].pinned, typed);
		end
		drain_results();

		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_pct[ph];
			rsp_stall_pct <= stall_pct[ph];
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 0 && n == 120) begin
					// long receiver hold with a busy sender backs the block up
					hold_tgl <= !hold_tgl;
					for (k = 0; k < 40; k++)
						offer_item(random_list_item(50), 1'b0, '0);
					drain_results();
				end
				offer_item(random_list_item(((n / 150) % 2 == 0) ? 75 : 25), 1'b0, '0);
			end
			drain_results();
		end

		repeat (8) @(posedge clk);
		if (err_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire

[sim.f]
+incdir+rtl
rtl/pol_pkg.sv
rtl/pol_cell.sv
rtl/positional_ordered_list.sv
bench/tb_positional_ordered_list.sv
